/* sv/swps_pkg.sv */
`timescale 1ns / 1ps

package swps_pkg;

    // input item kinds
    localparam logic [1:0] K_CHAR  = 2'd0;
    localparam logic [1:0] K_CLOSE = 2'd1;
    localparam logic [1:0] K_RESP  = 2'd2;
    localparam logic [1:0] K_TICK  = 2'd3;

    // result unit kinds
    localparam logic [1:0] UK_SEQ  = 2'd0;
    localparam logic [1:0] UK_DATA = 2'd1;
    localparam logic [1:0] UK_PAR  = 2'd2;
    localparam logic [1:0] UK_STAT = 2'd3;

    // status codes
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_DELIVERED = 2'd1;
    localparam logic [1:0] ST_FINISHED  = 2'd2;
    localparam logic [1:0] ST_ABORTED   = 2'd3;

    localparam logic [7:0] RESP_ACK = 8'd1;

    // configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 16;
    localparam logic [0:0] REG_RETRY_LIMIT = 1'b0;
    localparam logic [0:0] REG_TIMEOUT     = 1'b1;

    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd3;
    localparam logic [15:0] TIMEOUT_RST     = 16'd2000;

    // frame layout: sequence, 8 data bits, parity
    localparam int         UNIT_IDX_W = 4;
    localparam logic [3:0] UNIT_LAST  = 4'd9;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_WAIT  = 4'b0010,
        PH_DONE  = 4'b0100,
        PH_ABORT = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       is_frame;
        logic [7:0] seq;
        logic [7:0] data;
        logic [1:0] code;
    } cmd_t;

endpackage

/* sv/swps_front.sv */
`timescale 1ns / 1ps

module swps_front import swps_pkg::*; #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           kind,
    input  logic [7:0]           data_byte,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic [3:0]             retry_limit_reg;
    logic [15:0]            timeout_reg;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             seq_reg, seq_next;
    logic [7:0]             held_reg, held_next;
    logic                   closing_reg, closing_next;
    logic [3:0]             retries_reg, retries_next;
    logic [TIMER_WIDTH-1:0] wt_reg, wt_next;

    logic                   accept;
    logic                   do_retry;
    logic [TIMER_WIDTH-1:0] wt_inc;
    logic [15:0]            limit;
    logic                   timed_out;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign wt_inc    = (wt_reg != TMAX) ? wt_reg + 1'b1 : wt_reg;
    assign limit     = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign timed_out = (CW'(wt_inc) >= CW'(limit)) || (wt_inc == TMAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            timeout_reg     <= TIMEOUT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RETRY_LIMIT: retry_limit_reg <= cfg_data[3:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        seq_next     = seq_reg;
        held_next    = held_reg;
        closing_next = closing_reg;
        retries_next = retries_reg;
        wt_next      = wt_reg;
        do_retry     = 1'b0;
        q_push       = 1'b0;
        q_cmd        = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (kind == K_CHAR || kind == K_CLOSE)
                    begin
                        closing_next   = (kind == K_CLOSE);
                        held_next      = (kind == K_CLOSE) ? 8'd0 : data_byte;
                        retries_next   = 4'd0;
                        wt_next        = '0;
                        phase_next     = PH_WAIT;
                        q_push         = 1'b1;
                        q_cmd.is_frame = 1'b1;
                        q_cmd.seq      = seq_reg;
                        q_cmd.data     = held_next;
                    end
                end
                PH_WAIT:
                begin
                    if (kind == K_RESP)
                    begin
                        if (data_byte == RESP_ACK)
                        begin
                            wt_next = '0;
                            q_push  = 1'b1;
                            if (closing_reg)
                            begin
                                phase_next = PH_DONE;
                                q_cmd.code = ST_FINISHED;
                            end
                            else
                            begin
                                seq_next   = seq_reg + 8'd1;
                                phase_next = PH_IDLE;
                                q_cmd.code = ST_DELIVERED;
                            end
                        end
                        else
                        begin
                            do_retry = 1'b1;
                        end
                    end
                    else if (kind == K_TICK)
                    begin
                        wt_next  = wt_inc;
                        do_retry = timed_out;
                    end
                end
                default: ;
            endcase
            if (do_retry)
            begin
                wt_next = '0;
                q_push  = 1'b1;
                if (retries_reg < retry_limit_reg)
                begin
                    retries_next   = retries_reg + 4'd1;
                    q_cmd.is_frame = 1'b1;
                    q_cmd.seq      = seq_reg;
                    q_cmd.data     = held_reg;
                end
                else
                begin
                    phase_next = PH_ABORT;
                    q_cmd.code = ST_ABORTED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            seq_reg     <= 8'd0;
            held_reg    <= 8'd0;
            closing_reg <= 1'b0;
            retries_reg <= 4'd0;
            wt_reg      <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            held_reg    <= held_next;
            closing_reg <= closing_next;
            retries_reg <= retries_next;
            wt_reg      <= wt_next;
        end
    end

    // retries never run past the limit in force
    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_cmd.is_frame && phase_reg == PH_WAIT |=> retries_reg <= retry_limit_reg)
        else $error("retry count past limit");

    // every frame issue restarts the response timer
    a_timer_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_cmd.is_frame |=> wt_reg == '0 && phase_reg == PH_WAIT)
        else $error("timer not restarted after frame");

    // terminal phases stay put
    a_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE || phase_reg == PH_ABORT |=> $stable(phase_reg))
        else $error("left terminal phase");

endmodule

/* sv/swps_queue.sv */
`timescale 1ns / 1ps

module swps_queue import swps_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("queue underflow");

endmodule

/* sv/swps_back.sv */
`timescale 1ns / 1ps

module swps_back import swps_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] unit_value,
    output logic [1:0] unit_kind,
    output logic [1:0] status_code,
    output logic       last
);

    logic [UNIT_IDX_W-1:0] idx_reg;
    logic                  valid_reg;
    logic [7:0]            value_reg;
    logic [1:0]            kind_reg;
    logic [1:0]            status_reg;
    logic                  last_reg;

    logic                  load;
    logic [7:0]            u_value;
    logic [1:0]            u_kind;
    logic [1:0]            u_status;
    logic                  u_last;
    logic [7:0]            shifted;

    assign load    = (!valid_reg || !out_stall) && head_valid;
    assign shifted = head_cmd.data << 3'(idx_reg - 4'd1);

    always_comb
    begin
        u_value  = 8'd0;
        u_kind   = UK_STAT;
        u_status = ST_NONE;
        u_last   = 1'b1;
        if (!head_cmd.is_frame)
        begin
            u_value  = {6'd0, head_cmd.code};
            u_status = head_cmd.code;
        end
        else if (idx_reg == 4'd0)
        begin
            u_value = head_cmd.seq;
            u_kind  = UK_SEQ;
            u_last  = 1'b0;
        end
        else if (idx_reg == UNIT_LAST)
        begin
            u_value = {7'd0, ^head_cmd.data};
            u_kind  = UK_PAR;
        end
        else
        begin
            u_value = {7'd0, shifted[7]};
            u_kind  = UK_DATA;
            u_last  = 1'b0;
        end
    end

    assign pop = load && u_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= u_last ? '0 : idx_reg + 4'd1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg  <= u_value;
            kind_reg   <= u_kind;
            status_reg <= u_status;
            last_reg   <= u_last;
        end
    end

    assign out_valid   = valid_reg;
    assign unit_value  = value_reg;
    assign unit_kind   = kind_reg;
    assign status_code = status_reg;
    assign last        = last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= UNIT_LAST)
        else $error("unit index out of range");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> unit_kind == UK_PAR || unit_kind == UK_STAT)
        else $error("word marked last is not a frame end or status");

    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_code != ST_NONE |-> unit_kind == UK_STAT)
        else $error("status code on a frame word");

endmodule

/* sv/stop_and_wait_parity_sender_core.sv */
`timescale 1ns / 1ps

// Stop-and-wait sender with parity-protected serial frames.
// Input channel (in_valid/in_stall, kind, data_byte): kind 0 sends a character,
// 1 sends the closing frame, 2 delivers a response byte (1 = ACK), 3 is a tick.
// Output channel (out_valid/out_stall): one word per cycle while not stalled.
// A frame is ten words: sequence byte, eight data bits MSB first, odd-ones
// parity (last=1). A status word (delivered, finished, aborted) is a single
// word with last=1. The front section updates protocol state and accepts a
// word every cycle while its two-entry command queue has room; in_stall is
// the queue full flag. The back section serializes commands: a frame occupies
// it for its ten words, a status word for one. An accepted command passes
// through the queue entry and the output register before its first word appears.
// Output stall freezes the output register; the queue then fills and the
// input stalls. Reset clears state to idle, sequence 0, retry_limit 3,
// timeout_ticks 2000. Finished and aborted are held until reset.
// Config writes (cfg_wr_en, cfg_index, cfg_data) take effect next cycle.

module stop_and_wait_parity_sender_core import swps_pkg::*; #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            unit_value,
    output logic [1:0]            unit_kind,
    output logic [1:0]            status_code,
    output logic                  last,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic head_valid;
    cmd_t head_cmd;

    swps_front #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    swps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    swps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .unit_value  (unit_value),
        .unit_kind   (unit_kind),
        .status_code (status_code),
        .last        (last)
    );

endmodule

/* tb/stop_and_wait_parity_sender_core_test.sv */
`timescale 1ns / 1ps

module stop_and_wait_parity_sender_core_test;
    import swps_pkg::*;

    class arq_tracker;
        typedef struct {
            logic [7:0] value;
            logic [1:0] ukind;
            logic [1:0] code;
            logic       tail;
        } unit_t;

        unit_t      pending_units[$];
        phase_t     phase;
        logic [7:0] seq_num;
        logic [7:0] held;
        bit         closing;
        logic [3:0] retries;
        logic [3:0] retry_limit;
        logic [15:0] timeout;
        logic [15:0] waited;
        int         errors;
        int         checked;
        int         frames;
        int         delivered;

        function new();
            phase       = PH_IDLE;
            seq_num     = '0;
            held        = '0;
            closing     = 1'b0;
            retries     = '0;
            retry_limit = RETRY_LIMIT_RST;
            timeout     = TIMEOUT_RST;
            waited      = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_RETRY_LIMIT)
                retry_limit = val[3:0];
            else
                timeout = val[15:0];
        endfunction

        function void push_unit(logic [7:0] v, logic [1:0] k, logic [1:0] c, logic t);
            unit_t u;
            u.value = v;
            u.ukind = k;
            u.code  = c;
            u.tail  = t;
            pending_units.push_back(u);
        endfunction

        // sequence byte, data bits MSB first, odd-ones parity
        function void queue_frame();
            push_unit(seq_num, UK_SEQ, ST_NONE, 1'b0);
            for (int i = 7; i >= 0; i--)
                push_unit({7'd0, held[i]}, UK_DATA, ST_NONE, 1'b0);
            push_unit({7'd0, ^held}, UK_PAR, ST_NONE, 1'b1);
            phase  = PH_WAIT;
            waited = '0;
            frames++;
        endfunction

        function void queue_status(logic [1:0] code);
            push_unit({6'd0, code}, UK_STAT, code, 1'b1);
        endfunction

        function void retry_or_quit();
            if (retries < retry_limit) begin
                retries++;
                queue_frame();
            end
            else begin
                phase  = PH_ABORT;
                waited = '0;
                queue_status(ST_ABORTED);
            end
        endfunction

        // zero timeout counts as one; saturated counter always expires
        function bit tick_expires();
            logic [15:0] nxt;
            logic [15:0] lim;
            nxt = (waited == 16'hFFFF) ? waited : waited + 16'd1;
            lim = (timeout == 16'd0) ? 16'd1 : timeout;
            return (nxt >= lim) || (nxt == 16'hFFFF);
        endfunction

        function bit acts_on(logic [1:0] k);
            return (phase == PH_IDLE && (k == K_CHAR || k == K_CLOSE)) ||
                   (phase == PH_WAIT && (k == K_RESP || k == K_TICK));
        endfunction

        function void accept_word(logic [1:0] k, logic [7:0] d);
            bit expire;
            case (phase)
                PH_IDLE:
                begin
                    if (k == K_CHAR || k == K_CLOSE) begin
                        closing = (k == K_CLOSE);
                        held    = closing ? 8'h00 : d;
                        retries = '0;
                        queue_frame();
                    end
                end
                PH_WAIT:
                begin
                    if (k == K_RESP) begin
                        if (d == RESP_ACK) begin
                            waited = '0;
                            if (closing) begin
                                phase = PH_DONE;
                                queue_status(ST_FINISHED);
                            end
                            else begin
                                seq_num++;
                                phase = PH_IDLE;
                                delivered++;
                                queue_status(ST_DELIVERED);
                            end
                        end
                        else
                            retry_or_quit();
                    end
                    else if (k == K_TICK) begin
                        expire = tick_expires();
                        if (waited != 16'hFFFF)
                            waited++;
                        if (expire)
                            retry_or_quit();
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_unit(logic [7:0] v, logic [1:0] k, logic [1:0] c, logic t);
            unit_t want;
            if (pending_units.size() == 0) begin
                report_mismatch($sformatf("unexpected word value=%0d kind=%0d", v, k));
                return;
            end
            want = pending_units.pop_front();
            checked++;
            if (v !== want.value)
                report_mismatch($sformatf("unit_value %0d, want %0d", v, want.value));
            if (k !== want.ukind)
                report_mismatch($sformatf("unit_kind %0d, want %0d", k, want.ukind));
            if (c !== want.code)
                report_mismatch($sformatf("status_code %0d, want %0d", c, want.code));
            if (t !== want.tail)
                report_mismatch($sformatf("last %0b, want %0b", t, want.tail));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind = K_CHAR;
    logic [7:0]            data_byte = 8'd0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            unit_value;
    logic [1:0]            unit_kind;
    logic [1:0]            status_code;
    logic                  last;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_RETRY_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit         no_idle = 1'b0;
    int         hold_left = 0;
    int         stall_run = 0;
    int         words_sent = 0;
    arq_tracker tracker = new();

    stop_and_wait_parity_sender_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .unit_value  (unit_value),
        .unit_kind   (unit_kind),
        .status_code (status_code),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (stall_run > 0)
            stall_run--;
        else if (out_stall || no_idle) begin
            out_stall = 1'b0;
            stall_run = $urandom_range(0, 8);
        end
        else begin
            stall_run = pick_gap();
            out_stall = (stall_run != 0);
            if (stall_run != 0)
                stall_run--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_unit(unit_value, unit_kind, status_code, last);
    end

    task automatic send_word(input logic [1:0] k, input logic [7:0] d);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        kind      = k;
        data_byte = d;
        do
            @(posedge clk);
        while (in_stall);
        tracker.accept_word(k, d);
        words_sent++;
    endtask

    // drop valid, wait for all expected words, then let in-flight ticks settle
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending_units.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        tracker.set_reg(idx, val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_mode(input logic [3:0] retry, input logic [15:0] ticks);
        drain();
        write_reg(REG_RETRY_LIMIT, {12'd0, retry});
        write_reg(REG_TIMEOUT, ticks);
    endtask

    function automatic logic [7:0] nak_byte();
        return RESP_ACK ^ 8'($urandom_range(1, 255));
    endfunction

    // never drives the block into a terminal state
    task automatic choose_word(output logic [1:0] k, output logic [7:0] d);
        int  r;
        bit  spare;
        r     = $urandom_range(0, 99);
        d     = 8'($urandom_range(0, 255));
        spare = tracker.retries < tracker.retry_limit;
        if (tracker.phase == PH_IDLE)
            k = (r < 85) ? K_CHAR : ((r < 92) ? K_RESP : K_TICK);
        else if (r < 12)
            k = (r < 8) ? K_CHAR : K_CLOSE;
        else if (r < 45) begin
            k = K_RESP;
            d = RESP_ACK;
        end
        else if (r < 70) begin
            k = K_RESP;
            d = spare ? nak_byte() : RESP_ACK;
        end
        else if (spare || !tracker.tick_expires())
            k = K_TICK;
        else begin
            k = K_RESP;
            d = RESP_ACK;
        end
    endtask

    task automatic mixed_traffic(input int n);
        int         count;
        logic [1:0] k;
        logic [7:0] d;
        count = 0;
        while (count < n) begin
            choose_word(k, d);
            if (tracker.acts_on(k))
                count++;
            send_word(k, d);
        end
    endtask

    task automatic run_backlog(input int n);
        repeat (n) begin
            if (tracker.phase == PH_IDLE)
                send_word(K_CHAR, 8'($urandom_range(0, 255)));
            else if (tracker.retries < tracker.retry_limit && $urandom_range(0, 99) < 15)
                send_word(K_RESP, nak_byte());
            else
                send_word(K_RESP, RESP_ACK);
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values
        send_word(K_RESP, RESP_ACK);
        send_word(K_TICK, 8'hFF);
        send_word(K_CHAR, 8'h00);
        send_word(K_TICK, 8'h00);
        send_word(K_RESP, RESP_ACK);
        send_word(K_CHAR, 8'hFF);
        send_word(K_CHAR, 8'h5A);
        send_word(K_CLOSE, 8'h33);
        send_word(K_RESP, 8'h00);
        send_word(K_RESP, 8'hFF);
        send_word(K_RESP, 8'h02);
        send_word(K_RESP, RESP_ACK);
        send_word(K_CHAR, 8'h80);
        send_word(K_RESP, RESP_ACK);
        send_word(K_CHAR, 8'h01);
        send_word(K_RESP, RESP_ACK);

        set_mode(4'd15, 16'd1);
        mixed_traffic(45);
        set_mode(4'd0, 16'd3);
        mixed_traffic(35);
        set_mode(4'd7, 16'd0);
        mixed_traffic(45);
        set_mode(4'd4, 16'd6);
        no_idle = 1'b1;
        mixed_traffic(60);
        no_idle = 1'b0;
        set_mode(4'd15, 16'd2);
        mixed_traffic(45);
        set_mode(4'd3, 16'd10);
        mixed_traffic(35);

        // long output hold so the input backs up
        set_mode(4'd2, 16'd8);
        hold_left = 80;
        run_backlog(30);

        // longer timeout: counter runs up to the limit before the resend
        set_mode(4'd15, 16'd24);
        send_word(K_CHAR, 8'($urandom_range(0, 255)));
        no_idle = 1'b1;
        while (tracker.tick_expires() == 1'b0)
            send_word(K_TICK, 8'($urandom_range(0, 255)));
        send_word(K_TICK, 8'($urandom_range(0, 255)));
        no_idle = 1'b0;
        send_word(K_RESP, RESP_ACK);

        // closing frame, then finish or abort
        set_mode(4'd2, 16'd4);
        send_word(K_CLOSE, 8'($urandom_range(0, 255)));
        send_word(K_RESP, nak_byte());
        if ($urandom_range(0, 1))
            send_word(K_RESP, RESP_ACK);
        else
            while (tracker.phase == PH_WAIT) begin
                if ($urandom_range(0, 1))
                    send_word(K_RESP, nak_byte());
                else
                    send_word(K_TICK, 8'($urandom_range(0, 255)));
            end
        send_word(K_CHAR, 8'($urandom_range(0, 255)));
        send_word(K_CLOSE, 8'($urandom_range(0, 255)));
        send_word(K_RESP, RESP_ACK);
        send_word(K_TICK, 8'($urandom_range(0, 255)));

        drain();
        repeat (20) @(posedge clk);

        $display("Run covered %0d input words and %0d output words: %0d frames, %0d delivered",
                 words_sent, tracker.checked, tracker.frames, tracker.delivered);
        $display("Long output hold and timer expiry exercised; terminal state: %s",
                 (tracker.phase == PH_DONE) ? "finished" : "aborted");
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
